FILE: rtl/dssc_pkg.sv
// ----------------------------------------------------------------------------
// dssc_pkg
// Shared types, codes and the angle-to-compare map for the dual servo sweep
// controller.
// ----------------------------------------------------------------------------
package dssc_pkg;

  // request kinds
  localparam logic [1:0] REQ_SET_LEFT  = 2'd0;
  localparam logic [1:0] REQ_SET_RIGHT = 2'd1;
  localparam logic [1:0] REQ_FRONT     = 2'd2;
  localparam logic [1:0] REQ_SCAN      = 2'd3;

  // servo selection
  localparam logic [1:0] SIDE_BOTH  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_LEFT_MIN  = 2'd0;
  localparam logic [1:0] REG_LEFT_MAX  = 2'd1;
  localparam logic [1:0] REG_RIGHT_MIN = 2'd2;
  localparam logic [1:0] REG_RIGHT_MAX = 2'd3;

  localparam logic [15:0] RST_LEFT_MIN  = 16'd426;
  localparam logic [15:0] RST_LEFT_MAX  = 16'd1106;
  localparam logic [15:0] RST_RIGHT_MIN = 16'd834;
  localparam logic [15:0] RST_RIGHT_MAX = 16'd1514;

  // angle limits and step
  localparam logic [7:0] LEFT_HOME   = 8'd0;
  localparam logic [7:0] LEFT_LIMIT  = 8'd100;
  localparam logic [7:0] RIGHT_LOW   = 8'd70;
  localparam logic [7:0] RIGHT_HOME  = 8'd170;
  localparam logic [7:0] POS_MAX     = 8'd180;
  localparam logic [7:0] SCAN_STEP   = 8'd6;
  localparam logic [7:0] RIGHT_SHIFT = 8'd10;

  localparam int TDATA_IN_W  = 16;
  localparam int TUSER_IN_W  = 4;
  localparam int TDATA_OUT_W = 48;

  typedef struct packed {
    logic [15:0] left_min;
    logic [15:0] left_max;
    logic [15:0] right_min;
    logic [15:0] right_max;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  angle_right;
    logic [6:0]  angle_left;
    logic [15:0] right_pwm;
    logic [15:0] left_pwm;
  } servo_t;

  typedef struct packed {
    logic       [1:0] req_type;
    logic signed [9:0] position;
    logic       [1:0] side;
  } req_t;

  // 426 + 68*a/10; a/10 via reciprocal 6554/2^16, exact for 68*a below 16384
  // (a up to 159 is all that reaches here)
  function automatic logic [15:0] compare_map(input logic [7:0] a);
    logic [14:0] prod;
    logic [28:0] scaled;
    prod   = 15'(a) * 15'd68;
    scaled = 29'(prod) * 29'd6554;
    return 16'd426 + 16'(scaled[28:16]);
  endfunction

endpackage

FILE: rtl/dual_servo_sweep_controller.sv
// ----------------------------------------------------------------------------
// dual_servo_sweep_controller
// Two-servo position controller: set, home and scan requests update held
// angles and PWM compare values; each request returns the new servo state.
// ----------------------------------------------------------------------------
//   channel   dir  tdata                                tuser
//   s_axis    in   [9:0] position                       [1:0] req_type, [3:2] side
//   m_axis    out  [15:0] left_compare, [31:16] right_compare,
//                  [38:32] left_angle, [46:39] right_angle
//   cfg       in   cfg_index selects register, cfg_data written on cfg_we
//
// One request per cycle sustained while the output is not stalled; an input
// transfer loads the input register, then the state and result registers.
// The servo state updates in the same cycle the result register loads, so
// the next request always sees it.
// Synchronous reset clears state to zero and limit registers to defaults.
// An output stall holds the result; one more request waits in the input
// register, then s_tready drops.
// ----------------------------------------------------------------------------
module dual_servo_sweep_controller
  import dssc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // [9:0] position
  input  logic [TUSER_IN_W-1:0]  s_tuser,   // [1:0] req_type, [3:2] side
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // left_compare, right_compare,
                                            // left_angle, right_angle
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  cfg_t   cfg;
  req_t   in_req;
  logic   in_valid;
  servo_t state;
  servo_t state_next;
  servo_t result;
  logic   advance;

  dssc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dssc_step u_step (
    .cfg (cfg),
    .req (in_req),
    .cur (state),
    .nxt (state_next)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req.req_type <= s_tuser[1:0];
      in_req.position <= s_tdata[9:0];
      in_req.side     <= s_tuser[3:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      state    <= state_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= state_next;
    end
  end

  assign m_tdata = {1'b0, result.angle_right, result.angle_left,
                    result.right_pwm, result.left_pwm};

endmodule

FILE: rtl/dssc_cfg.sv
// ----------------------------------------------------------------------------
// dssc_cfg
// Compare limit registers, written through the plain configuration port.
// ----------------------------------------------------------------------------
module dssc_cfg
  import dssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_min  <= RST_LEFT_MIN;
      cfg.left_max  <= RST_LEFT_MAX;
      cfg.right_min <= RST_RIGHT_MIN;
      cfg.right_max <= RST_RIGHT_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_MIN:  cfg.left_min  <= cfg_data;
        REG_LEFT_MAX:  cfg.left_max  <= cfg_data;
        REG_RIGHT_MIN: cfg.right_min <= cfg_data;
        REG_RIGHT_MAX: cfg.right_max <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/dssc_step.sv
// ----------------------------------------------------------------------------
// dssc_step
// Next servo state for one request: target selection, clamp and compare map.
// ----------------------------------------------------------------------------
module dssc_step
  import dssc_pkg::*;
(
  input  cfg_t   cfg,
  input  req_t   req,
  input  servo_t cur,
  output servo_t nxt
);

  logic               left_en;
  logic               right_en;
  logic signed [10:0] left_p;
  logic signed [10:0] right_p;
  logic               left_ok;
  logic               right_ok;
  logic [7:0]         right_off;

  // pick which servo moves and to what target angle
  always_comb begin
    left_en  = 1'b0;
    right_en = 1'b0;
    left_p   = 11'sd0;
    right_p  = 11'sd0;
    case (req.req_type)
      REQ_SET_LEFT: begin
        left_en = 1'b1;
        left_p  = 11'(req.position);
      end
      REQ_SET_RIGHT: begin
        right_en = 1'b1;
        right_p  = 11'(req.position);
      end
      REQ_FRONT: begin
        left_en  = (req.side == SIDE_BOTH) || (req.side == SIDE_LEFT);
        right_en = (req.side == SIDE_BOTH) || (req.side == SIDE_RIGHT);
        left_p   = 11'(LEFT_HOME);
        right_p  = 11'(RIGHT_HOME);
      end
      REQ_SCAN: begin
        left_en  = (req.side == SIDE_LEFT);
        right_en = (req.side == SIDE_RIGHT);
        left_p   = (8'(cur.angle_left) >= LEFT_LIMIT) ? 11'(LEFT_HOME)
                 : 11'(8'(cur.angle_left) + SCAN_STEP);
        // reset angle 0 also falls into the wrap to home
        right_p  = (cur.angle_right <= RIGHT_LOW) ? 11'(RIGHT_HOME)
                 : 11'(cur.angle_right - SCAN_STEP);
      end
      default: ;
    endcase
  end

  assign left_ok   = left_en  && (left_p  >= 0) && (left_p  <= 11'(POS_MAX));
  assign right_ok  = right_en && (right_p >= 0) && (right_p <= 11'(POS_MAX));
  assign right_off = right_p[7:0] - RIGHT_SHIFT;

  always_comb begin
    nxt = cur;
    if (left_ok) begin
      if (left_p == 0) begin
        nxt.left_pwm   = cfg.left_min;
        nxt.angle_left = 7'(LEFT_HOME);
      end else if (left_p >= 11'(LEFT_LIMIT)) begin
        nxt.left_pwm   = cfg.left_max;
        nxt.angle_left = 7'(LEFT_LIMIT);
      end else begin
        nxt.left_pwm   = compare_map({1'b0, left_p[6:0]});
        nxt.angle_left = left_p[6:0];
      end
    end
    if (right_ok) begin
      if (right_p <= 11'(RIGHT_LOW)) begin
        nxt.right_pwm   = cfg.right_min;
        nxt.angle_right = RIGHT_LOW;
      end else if (right_p >= 11'(RIGHT_HOME)) begin
        nxt.right_pwm   = cfg.right_max;
        nxt.angle_right = RIGHT_HOME;
      end else begin
        nxt.right_pwm   = compare_map(right_off);
        nxt.angle_right = right_p[7:0];
      end
    end
  end

endmodule

FILE: rtl/dssc_checker.sv
// ----------------------------------------------------------------------------
// dssc_checker
// Port-level checks on the servo controller's result stream.
// ----------------------------------------------------------------------------
module dssc_checker
  import dssc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [TDATA_OUT_W-1:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_left_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[38:32] <= 7'd100)
    else $error("left angle out of range");

  a_right_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[46:39] == 8'd0) ||
                 ((m_tdata[46:39] >= 8'd70) && (m_tdata[46:39] <= 8'd170)))
    else $error("right angle out of range");

  // input side never blocks when output is free and nothing is waiting
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind dual_servo_sweep_controller dssc_checker u_dssc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
